// ----- design/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared widths, constants, seed words and types for the buzhash stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package bhs_pkg;

    localparam int HASH_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 1 << BYTE_W;
    localparam int SEED_COUNT  = 32;
    localparam int SEED_AW     = $clog2(SEED_COUNT);

    // finalizer multipliers
    localparam logic [HASH_W-1:0] MIX_MUL0 = 32'h9e37_79b9;
    localparam logic [HASH_W-1:0] MIX_MUL1 = 32'h7feb_352d;
    localparam logic [HASH_W-1:0] MIX_MUL2 = 32'h846c_a68b;

    // write beat from the finalizer pipeline into the mix table
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] addr;
    } mix_wr_t;

    // fixed mix words for the low byte values
    function automatic logic [HASH_W-1:0] seed_word(input logic [SEED_AW-1:0] idx);
        logic [HASH_W-1:0] w;
        case (idx)
            5'd0:    w = 32'h02a6_5c15;
            5'd1:    w = 32'h7b1f_2a3e;
            5'd2:    w = 32'h9e3c_6f1b;
            5'd3:    w = 32'h3c4d_6f2a;
            5'd4:    w = 32'h11b4_d2d7;
            5'd5:    w = 32'ha0c3_e19d;
            5'd6:    w = 32'h5c2a_9d47;
            5'd7:    w = 32'h8f1c_3a52;
            5'd8:    w = 32'h6d3e_2a19;
            5'd9:    w = 32'h4a7c_1d2e;
            5'd10:   w = 32'h1f2e_3d4c;
            5'd11:   w = 32'h89ab_12cd;
            5'd12:   w = 32'hf1e2_d3c4;
            5'd13:   w = 32'h1357_9bdf;
            5'd14:   w = 32'h2468_ace0;
            5'd15:   w = 32'h0f1e_2d3c;
            5'd16:   w = 32'h4b5a_6978;
            5'd17:   w = 32'h98a7_b6c5;
            5'd18:   w = 32'h1122_3344;
            5'd19:   w = 32'h5566_7788;
            5'd20:   w = 32'h99aa_bbcc;
            5'd21:   w = 32'hddee_ff00;
            5'd22:   w = 32'hc001_d00d;
            5'd23:   w = 32'hdead_beef;
            5'd24:   w = 32'habcd_ef01;
            5'd25:   w = 32'h10fe_dcba;
            5'd26:   w = 32'h7654_3210;
            5'd27:   w = 32'hfedc_ba98;
            5'd28:   w = 32'h89ab_cdef;
            5'd29:   w = 32'h0123_4567;
            5'd30:   w = 32'h3f2e_1d0c;
            5'd31:   w = 32'h0c1d_2e3f;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/bhs_ram.sv -----
// ----------------------------------------------------------------------------
// bhs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/bhs_mix.sv -----
// ----------------------------------------------------------------------------
// bhs_mix
// Four-stage finalizer pipeline producing the mix word of one byte value.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_mix (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic [bhs_pkg::BYTE_W-1:0]  in_value,
    output bhs_pkg::mix_wr_t                 wr_o,
    output logic      [bhs_pkg::HASH_W-1:0]  word_o
);
    import bhs_pkg::*;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [BYTE_W-1:0]    s1_addr_reg, s2_addr_reg, s3_addr_reg, s4_addr_reg;
    logic [HASH_W-1:0]    s1_m_reg, s2_m_reg, s3_m_reg, s4_word_reg;
    logic [BYTE_W:0]      v_inc;
    logic [HASH_W+BYTE_W:0] p1;
    logic [HASH_W-1:0]    x2, x3, x4;
    logic [2*HASH_W-1:0]  p2, p3;
    logic [HASH_W-1:0]    s4_word_next;

    // one multiply in each stage but the last, which picks a seed word or the mixed word
    always_comb begin
        v_inc        = {1'b0, in_value} + (BYTE_W+1)'(1);
        p1           = v_inc * MIX_MUL0;
        x2           = s1_m_reg ^ (s1_m_reg >> 16);
        p2           = x2 * MIX_MUL1;
        x3           = s2_m_reg ^ (s2_m_reg >> 15);
        p3           = x3 * MIX_MUL2;
        x4           = s3_m_reg ^ (s3_m_reg >> 16);
        s4_word_next = (s3_addr_reg < BYTE_W'(SEED_COUNT))
                     ? seed_word(s3_addr_reg[SEED_AW-1:0]) : x4;
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // payload chain
    always_ff @(posedge aclk) begin
        s1_addr_reg <= in_value;
        s1_m_reg    <= p1[HASH_W-1:0];
        s2_addr_reg <= s1_addr_reg;
        s2_m_reg    <= p2[HASH_W-1:0];
        s3_addr_reg <= s2_addr_reg;
        s3_m_reg    <= p3[HASH_W-1:0];
        s4_addr_reg <= s3_addr_reg;
        s4_word_reg <= s4_word_next;
    end

    assign wr_o.valid = s4_valid_reg;
    assign wr_o.addr  = s4_addr_reg;
    assign word_o     = s4_word_reg;

endmodule

`default_nettype wire

// ----- design/buzhash32_stream.sv -----
// ----------------------------------------------------------------------------
// buzhash32_stream
// Whole-message 32-bit buzhash over a byte stream, mix words from a table RAM.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser  tlast
//  s_        in   [7:0] data_byte       -      end_of_message
//  m_        out  [31:0] hash_value     -      -
//
//  one byte beat per cycle: the mix table RAM is read on acceptance and the
//  rotate-xor into the running hash happens on the following cycle
//  after a last beat the input pauses while the hash is handed over;
//  it also waits while a finished hash sits unaccepted on m_
//  after reset a fill pass loads the 256-entry mix table through
//  the finalizer pipeline; s_tready stays low until it ends
// ----------------------------------------------------------------------------
`default_nettype none

module buzhash32_stream (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [bhs_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [bhs_pkg::HASH_W-1:0]  m_tdata    // [31:0] hash_value
);
    import bhs_pkg::*;

    localparam int CNT_W = BYTE_W + 1;

    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              fill_done_reg;
    mix_wr_t           mix_wr;
    logic [HASH_W-1:0] mix_word;
    logic [HASH_W-1:0] ram_rdata;
    logic              s_accept;
    logic              p_valid_reg, p_last_reg;
    logic [HASH_W-1:0] hash_reg, hash_next, hash_upd;
    logic              m_tvalid_reg;
    logic [HASH_W-1:0] m_tdata_reg;

    // fill pass: issue every byte value once into the finalizer
    assign issue_cnt_next = issue_cnt_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
            fill_done_reg <= 1'b0;
        end else begin
            if (!issue_cnt_reg[BYTE_W]) begin
                issue_cnt_reg <= issue_cnt_next;
            end
            if (mix_wr.valid && (mix_wr.addr == BYTE_W'(TABLE_DEPTH - 1))) begin
                fill_done_reg <= 1'b1;
            end
        end
    end

    bhs_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!issue_cnt_reg[BYTE_W]),
        .in_value (issue_cnt_reg[BYTE_W-1:0]),
        .wr_o     (mix_wr),
        .word_o   (mix_word)
    );

    bhs_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (mix_wr.valid),
        .waddr (mix_wr.addr),
        .wdata (mix_word),
        .re    (s_accept),
        .raddr (s_tdata),
        .rdata (ram_rdata)
    );

    // input handshake: hold off in the fill pass, a last-beat handover or while m_ is stalled
    assign s_tready = fill_done_reg && !(p_valid_reg && p_last_reg)
                    && !(m_tvalid_reg && !m_tready);
    assign s_accept = s_tvalid && s_tready;

    // rotate-xor update of the running hash, cleared to zero after a last beat
    always_comb begin
        hash_upd  = {hash_reg[HASH_W-2:0], hash_reg[HASH_W-1]} ^ ram_rdata;
        hash_next = hash_reg;
        if (p_valid_reg) begin
            hash_next = p_last_reg ? '0 : hash_upd;
        end
    end

    // lookup stage, running hash and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            hash_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            p_valid_reg <= s_accept;
            p_last_reg  <= s_tlast;
            hash_reg    <= hash_next;
            if (p_valid_reg && p_last_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_valid_reg && p_last_reg) begin
            m_tdata_reg <= hash_upd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // a finished hash never lands on an unaccepted result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(p_valid_reg && p_last_reg && m_tvalid_reg && !m_tready))
        else $error("result overwritten before acceptance");

    // the running hash restarts from zero after a last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && p_last_reg |=> hash_reg == '0)
        else $error("running hash not cleared after last beat");

    // no table writes once the fill pass has completed
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_done_reg |-> !mix_wr.valid)
        else $error("table write after fill pass");
`endif

endmodule

`default_nettype wire
